### hw/rtl/efla_pkg.sv
// Shared types, constants and request codes of the explicit free list allocator.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps
package efla_pkg;

   // heap memory geometry
   localparam int HEAP_WORDS = 16384;
   localparam int MEM_AW     = $clog2(HEAP_WORDS);
   localparam int CAP_BYTES  = (HEAP_WORDS * 4 > 65536) ? 65536 : HEAP_WORDS * 4;
   localparam int STEP_W     = $clog2(HEAP_WORDS + 1);

   // byte addresses carry headroom for address + size sums
   localparam int ADDR_W = 18;
   localparam int SIZE_W = 17;
   // tags (size | alloc) and link words never exceed 17 bits
   localparam int WORD_W = 17;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [SIZE_W-1:0] size_type;
   typedef logic [WORD_W-1:0] word_type;
   typedef logic [15:0]       link_type;

   // request codes
   localparam logic [1:0] OP_INIT   = 2'd0;
   localparam logic [1:0] OP_ALLOC  = 2'd1;
   localparam logic [1:0] OP_FREE   = 2'd2;
   localparam logic [1:0] OP_RESIZE = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_NONE    = 2'd2;

   localparam size_type CHUNK_RESET = size_type'(1 << 12);
   localparam size_type SPLIT_MIN   = size_type'(24);
   localparam size_type MIN_BLOCK   = size_type'(16);
   localparam addr_type CAP_ADDR    = addr_type'(CAP_BYTES);
   localparam addr_type AVAIL_INIT  = addr_type'((CAP_BYTES - 16) & ~7);

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] req_size;
      logic [15:0] block_addr;
   } req_type;

   typedef struct packed {
      logic [15:0] result_addr;
      logic [1:0]  status;
      logic [15:0] copy_src;
      logic [15:0] copy_bytes;
   } rsp_type;

   // one access per cycle to the heap memory
   typedef struct packed {
      logic     we;
      addr_type addr;
      word_type wdata;
   } mem_req_type;

   // shared add / subtract unit
   typedef struct packed {
      addr_type a;
      addr_type b;
      logic     sub;
   } alu_req_type;

   typedef struct packed {
      addr_type y;
      logic     neg;
   } alu_rsp_type;

   // clear the low three bits
   function automatic addr_type align8(addr_type v);
      return v & ~addr_type'(7);
   endfunction

endpackage

### hw/rtl/efla_alu.sv
// Shared adder / subtractor of the allocator, used by the sequencer steps.
// Depends on efla_pkg.
`timescale 1ns / 1ps
module efla_alu (
   input  efla_pkg::alu_req_type alu_req,
   output efla_pkg::alu_rsp_type alu_rsp
);
   import efla_pkg::*;

   logic [ADDR_W:0] wide;

   // one add or subtract; borrow reports a < b
   always_comb begin
      if (alu_req.sub) begin
         wide = {1'b0, alu_req.a} - {1'b0, alu_req.b};
      end else begin
         wide = {1'b0, alu_req.a} + {1'b0, alu_req.b};
      end
      alu_rsp.y   = wide[ADDR_W-1:0];
      alu_rsp.neg = alu_req.sub & wide[ADDR_W];
   end

endmodule

### hw/rtl/efla_mem.sv
// Heap word memory: one access per cycle, registered read data.
// Depends on efla_pkg. Misaligned or out-of-range accesses read zero and drop writes.
`timescale 1ns / 1ps
module efla_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  efla_pkg::mem_req_type mem_req,
   output efla_pkg::word_type    mem_rdata
);
   import efla_pkg::*;

   word_type              mem [HEAP_WORDS];
   logic [ADDR_W-3:0]     widx;
   logic [MEM_AW-1:0]     idx;
   logic                  in_range;
   word_type              q_ff;
   logic                  rok_ff;
   logic                  rok_in;

   // word index and range check
   always_comb begin
      widx     = mem_req.addr[ADDR_W-1:2];
      idx      = MEM_AW'(widx);
      in_range = (mem_req.addr[1:0] == 2'b00) && (32'(widx) < 32'(HEAP_WORDS));
      rok_in   = in_range;
   end

   // storage
   always_ff @(posedge clock) begin
      if (mem_req.we && in_range) begin
         mem[idx] <= mem_req.wdata;
      end
      q_ff <= mem[idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rok_ff <= 1'b0;
      end else begin
         rok_ff <= rok_in;
      end
   end

   assign mem_rdata = rok_ff ? q_ff : '0;

endmodule

### hw/rtl/efla_seq.sv
// Request sequencer of the allocator: list walks, tags, split, coalesce, growth.
// Depends on efla_pkg; drives efla_alu and efla_mem one step per cycle.
`timescale 1ns / 1ps
module efla_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  efla_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output efla_pkg::rsp_type     rsp_data,
   input  logic                  csr_valid,
   input  efla_pkg::size_type    csr_data,
   output efla_pkg::alu_req_type alu_req,
   input  efla_pkg::alu_rsp_type alu_rsp,
   output efla_pkg::mem_req_type mem_req,
   input  efla_pkg::word_type    mem_rdata
);
   import efla_pkg::*;

   localparam logic [6:0] S_IDLE = 7'd0,  S_DISP = 7'd1,  S_I0 = 7'd2,   S_I1 = 7'd3;
   localparam logic [6:0] S_I2 = 7'd4,    S_I3 = 7'd5,    S_I4 = 7'd6,   S_I5 = 7'd7;
   localparam logic [6:0] S_I6 = 7'd8,    S_IEND = 7'd9,  S_E0 = 7'd10,  S_E1 = 7'd11;
   localparam logic [6:0] S_E2 = 7'd12,   S_E3 = 7'd13,   S_C0 = 7'd14,  S_C1 = 7'd15;
   localparam logic [6:0] S_C2 = 7'd16,   S_C3 = 7'd17,   S_C4 = 7'd18,  S_C6 = 7'd19;
   localparam logic [6:0] S_CRN = 7'd20,  S_C7 = 7'd21,   S_CT = 7'd22,  S_T0 = 7'd23;
   localparam logic [6:0] S_T1 = 7'd24,   S_T2 = 7'd25,   S_P0 = 7'd26,  S_P1 = 7'd27;
   localparam logic [6:0] S_P2 = 7'd28,   S_L0 = 7'd29,   S_L1 = 7'd30,  S_L2 = 7'd31;
   localparam logic [6:0] S_L3 = 7'd32,   S_A0 = 7'd33,   S_F1 = 7'd34,  S_F2 = 7'd35;
   localparam logic [6:0] S_F3 = 7'd36,   S_F4 = 7'd37,   S_G0 = 7'd38,  S_G1 = 7'd39;
   localparam logic [6:0] S_G2 = 7'd40,   S_G3 = 7'd41,   S_G4 = 7'd42,  S_PL0 = 7'd43;
   localparam logic [6:0] S_PL1 = 7'd44,  S_PL2 = 7'd45,  S_PL3 = 7'd46, S_PL4 = 7'd47;
   localparam logic [6:0] S_PL5 = 7'd48,  S_AOK = 7'd49,  S_OPS = 7'd50, S_V0 = 7'd51;
   localparam logic [6:0] S_V1 = 7'd52,   S_V2 = 7'd53,   S_V3 = 7'd54,  S_FR0 = 7'd55;
   localparam logic [6:0] S_FR1 = 7'd56,  S_RZ0 = 7'd57,  S_RZ1 = 7'd58, S_RZ2 = 7'd59;
   localparam logic [6:0] S_RZ3 = 7'd60,  S_RZ4 = 7'd61,  S_RZ5 = 7'd62, S_AB1 = 7'd63;
   localparam logic [6:0] S_MV1 = 7'd64,  S_MV2 = 7'd65,  S_DONE = 7'd66;

   // control state
   logic [6:0] state_ff, state_in;
   logic       ready_ff, ready_in;
   link_type   fh_ff, fh_in;
   size_type   top_ff, top_in;
   size_type   chunk_ff, chunk_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   // subroutine return points
   logic [6:0] lr_ret_ff, lr_ret_in, co_ret_ff, co_ret_in, t_ret_ff, t_ret_in;
   logic [6:0] al_ret_ff, al_ret_in, ext_ret_ff, ext_ret_in;

   // request and working registers
   logic [1:0]  op_ff, op_in;
   logic [15:0] size_ff, size_in, addr_ff, addr_in;
   link_type    res_ff, res_in, csrc_ff, csrc_in, cbytes_ff, cbytes_in;
   logic [1:0]  st_ff, st_in;
   addr_type    bp_ff, bp_in, nb_ff, nb_in, tb_ff, tb_in, tt_ff, tt_in;
   addr_type    g_ff, g_in, abp_ff, abp_in, lx_ff, lx_in;
   size_type    s_ff, s_in, ps_ff, ps_in, ns_ff, ns_in, tsz_ff, tsz_in;
   size_type    asize_ff, asize_in, pcs_ff, pcs_in, vcs_ff, vcs_in, rem_ff, rem_in;
   logic        pa_ff, pa_in, na_ff, na_in, tal_ff, tal_in, rem_ok_ff, rem_ok_in;
   link_type    lp_ff, lp_in, ln_ff, ln_in, fp_ff, fp_in;
   logic [STEP_W-1:0] steps_ff, steps_in;

   size_type  dsz;
   link_type  d16;
   addr_type  y;
   logic      neg;
   logic      load;

   assign dsz = {mem_rdata[WORD_W-1:3], 3'b000};
   assign d16 = mem_rdata[15:0];
   assign y   = alu_rsp.y;
   assign neg = alu_rsp.neg;

   // shared unit operands per step
   always_comb begin
      alu_req = '{a: '0, b: '0, sub: 1'b0};
      case (state_ff)
         S_I0:  alu_req = '{a: addr_type'(chunk_ff), b: addr_type'(7), sub: 1'b0};
         S_I1:  alu_req = '{a: g_ff, b: addr_type'(16), sub: 1'b1};
         S_I2:  alu_req = '{a: AVAIL_INIT, b: g_ff, sub: 1'b1};
         S_I4:  alu_req = '{a: '0, b: addr_type'(4), sub: 1'b0};
         S_I5:  alu_req = '{a: '0, b: addr_type'(8), sub: 1'b0};
         S_I6:  alu_req = '{a: '0, b: addr_type'(12), sub: 1'b0};
         S_E0:  alu_req = '{a: addr_type'(top_ff), b: addr_type'(4), sub: 1'b1};
         S_E1:  alu_req = '{a: bp_ff, b: g_ff, sub: 1'b0};
         S_E2:  alu_req = '{a: tt_ff, b: addr_type'(8), sub: 1'b1};
         S_E3:  alu_req = '{a: tt_ff, b: addr_type'(4), sub: 1'b1};
         S_C0:  alu_req = '{a: bp_ff, b: addr_type'(4), sub: 1'b1};
         S_C1:  alu_req = '{a: bp_ff, b: addr_type'(dsz), sub: 1'b0};
         S_C2:  alu_req = '{a: bp_ff, b: addr_type'(8), sub: 1'b1};
         S_C3:  alu_req = '{a: nb_ff, b: addr_type'(4), sub: 1'b1};
         S_C4:  alu_req = '{a: bp_ff, b: addr_type'(ps_ff), sub: 1'b1};
         S_C6:  alu_req = '{a: addr_type'(s_ff), b: addr_type'(ps_ff), sub: 1'b0};
         S_C7:  alu_req = '{a: addr_type'(s_ff), b: addr_type'(ns_ff), sub: 1'b0};
         S_T0:  alu_req = '{a: tb_ff, b: addr_type'(4), sub: 1'b1};
         S_T1:  alu_req = '{a: tb_ff, b: addr_type'(tsz_ff), sub: 1'b0};
         S_T2:  alu_req = '{a: tt_ff, b: addr_type'(8), sub: 1'b1};
         S_P0:  alu_req = '{a: bp_ff, b: addr_type'(4), sub: 1'b0};
         S_P1:  alu_req = '{a: addr_type'(fh_ff), b: '0, sub: 1'b0};
         S_P2:  alu_req = '{a: bp_ff, b: '0, sub: 1'b0};
         S_L0:  alu_req = '{a: lx_ff, b: '0, sub: 1'b0};
         S_L1:  alu_req = '{a: lx_ff, b: addr_type'(4), sub: 1'b0};
         S_L2:  alu_req = '{a: addr_type'(lp_ff), b: addr_type'(4), sub: 1'b0};
         S_L3:  alu_req = '{a: addr_type'(ln_ff), b: '0, sub: 1'b0};
         S_A0:  alu_req = '{a: addr_type'(size_ff), b: addr_type'(15), sub: 1'b0};
         S_F1:  alu_req = '{a: addr_type'(fp_ff), b: addr_type'(4), sub: 1'b1};
         S_F2:  alu_req = '{a: addr_type'(dsz), b: addr_type'(asize_ff), sub: 1'b1};
         S_F3:  alu_req = '{a: addr_type'(fp_ff), b: addr_type'(4), sub: 1'b0};
         S_G0:  alu_req = '{a: addr_type'(chunk_ff), b: addr_type'(7), sub: 1'b0};
         S_G1:  alu_req = '{a: g_ff, b: addr_type'(asize_ff), sub: 1'b1};
         S_G2:  alu_req = '{a: CAP_ADDR, b: addr_type'(top_ff), sub: 1'b1};
         S_G3:  alu_req = '{a: tt_ff, b: g_ff, sub: 1'b1};
         S_G4:  alu_req = '{a: g_ff, b: addr_type'(asize_ff), sub: 1'b1};
         S_PL0: alu_req = '{a: bp_ff, b: addr_type'(4), sub: 1'b1};
         S_PL2: alu_req = '{a: addr_type'(pcs_ff), b: addr_type'(asize_ff), sub: 1'b1};
         S_PL4: alu_req = '{a: abp_ff, b: addr_type'(asize_ff), sub: 1'b0};
         S_V0:  alu_req = '{a: addr_type'(addr_ff), b: addr_type'(top_ff), sub: 1'b1};
         S_V1:  alu_req = '{a: addr_type'(addr_ff), b: addr_type'(4), sub: 1'b1};
         S_V2:  alu_req = '{a: addr_type'(addr_ff), b: addr_type'(dsz), sub: 1'b0};
         S_V3:  alu_req = '{a: addr_type'(top_ff), b: tt_ff, sub: 1'b1};
         S_RZ0: alu_req = '{a: nb_ff, b: addr_type'(4), sub: 1'b1};
         S_RZ1: alu_req = '{a: addr_type'(size_ff), b: addr_type'(16), sub: 1'b0};
         S_RZ2: alu_req = '{a: addr_type'(vcs_ff), b: tt_ff, sub: 1'b1};
         S_RZ3: alu_req = '{a: addr_type'(ns_ff), b: addr_type'(vcs_ff), sub: 1'b0};
         S_RZ4: alu_req = '{a: addr_type'(size_ff), b: addr_type'(8), sub: 1'b0};
         S_RZ5: alu_req = '{a: tt_ff, b: addr_type'(tsz_ff), sub: 1'b1};
         S_MV1: alu_req = '{a: addr_type'(vcs_ff), b: addr_type'(8), sub: 1'b1};
         S_MV2: alu_req = '{a: addr_type'(size_ff), b: tt_ff, sub: 1'b1};
         default: alu_req = '{a: '0, b: '0, sub: 1'b0};
      endcase
   end

   // sequencer and datapath next state
   always_comb begin
      state_in = state_ff;   ready_in = ready_ff;   fh_in = fh_ff;     top_in = top_ff;
      chunk_in = csr_valid ? csr_data : chunk_ff;
      lr_ret_in = lr_ret_ff; co_ret_in = co_ret_ff; t_ret_in = t_ret_ff;
      al_ret_in = al_ret_ff; ext_ret_in = ext_ret_ff;
      op_in = op_ff;   size_in = size_ff;   addr_in = addr_ff;
      res_in = res_ff; st_in = st_ff;       csrc_in = csrc_ff; cbytes_in = cbytes_ff;
      bp_in = bp_ff;   nb_in = nb_ff;       tb_in = tb_ff;     tt_in = tt_ff;
      g_in = g_ff;     abp_in = abp_ff;     lx_in = lx_ff;
      s_in = s_ff;     ps_in = ps_ff;       ns_in = ns_ff;     tsz_in = tsz_ff;
      asize_in = asize_ff; pcs_in = pcs_ff; vcs_in = vcs_ff;   rem_in = rem_ff;
      pa_in = pa_ff;   na_in = na_ff;       tal_in = tal_ff;   rem_ok_in = rem_ok_ff;
      lp_in = lp_ff;   ln_in = ln_ff;       fp_in = fp_ff;     steps_in = steps_ff;
      mem_req = '{we: 1'b0, addr: y, wdata: '0};
      load = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_data.opcode;  size_in = req_data.req_size;
               addr_in = req_data.block_addr;
               res_in = '0; st_in = ST_OK; csrc_in = '0; cbytes_in = '0;
               state_in = S_DISP;
            end
         end
         S_DISP: state_in = (op_ff == OP_INIT || !ready_ff) ? S_I0 : S_OPS;

         // init: clamp chunk, write prologue and epilogue, extend
         S_I0: begin
            g_in = align8(y);  state_in = S_I1;
         end
         S_I1: begin
            if (neg) g_in = addr_type'(16);
            state_in = S_I2;
         end
         S_I2: begin
            if (neg) g_in = AVAIL_INIT;
            state_in = S_I3;
         end
         S_I3: begin
            mem_req.we = 1'b1;  state_in = S_I4;
         end
         S_I4: begin
            mem_req.we = 1'b1; mem_req.wdata = word_type'(9); state_in = S_I5;
         end
         S_I5: begin
            mem_req.we = 1'b1; mem_req.wdata = word_type'(9); state_in = S_I6;
         end
         S_I6: begin
            mem_req.we = 1'b1; mem_req.wdata = word_type'(1);
            fh_in = '0; top_in = size_type'(16); ready_in = 1'b1;
            ext_ret_in = S_IEND; state_in = S_E0;
         end
         S_IEND: state_in = S_OPS;

         // extend heap by g at the old top
         S_E0: begin
            mem_req.we = 1'b1; mem_req.wdata = word_type'(g_ff);
            bp_in = addr_type'(top_ff); state_in = S_E1;
         end
         S_E1: begin
            tt_in = y; state_in = S_E2;
         end
         S_E2: begin
            mem_req.we = 1'b1; mem_req.wdata = word_type'(g_ff); state_in = S_E3;
         end
         S_E3: begin
            mem_req.we = 1'b1; mem_req.wdata = word_type'(1);
            top_in = tt_ff[SIZE_W-1:0]; co_ret_in = ext_ret_ff; state_in = S_C0;
         end

         // coalesce bp with free neighbors, then push it
         S_C0: state_in = S_C1;
         S_C1: begin
            s_in = dsz; nb_in = y; state_in = S_C2;
         end
         S_C2: state_in = S_C3;
         S_C3: begin
            pa_in = mem_rdata[0]; ps_in = dsz; state_in = S_C4;
         end
         S_C4: begin
            na_in = mem_rdata[0]; ns_in = dsz;
            if (!pa_ff) begin
               lx_in = y; lr_ret_in = S_C6; state_in = S_L0;
            end else if (!mem_rdata[0]) begin
               state_in = S_CRN;
            end else begin
               state_in = S_P0;
            end
         end
         S_C6: begin
            s_in = size_type'(y); bp_in = lx_ff;
            state_in = na_ff ? S_CT : S_CRN;
         end
         S_CRN: begin
            lx_in = nb_ff; lr_ret_in = S_C7; state_in = S_L0;
         end
         S_C7: begin
            s_in = size_type'(y); state_in = S_CT;
         end
         S_CT: begin
            tb_in = bp_ff; tsz_in = s_ff; tal_in = 1'b0; t_ret_in = S_P0; state_in = S_T0;
         end

         // header and footer write
         S_T0: begin
            mem_req.we = 1'b1; mem_req.wdata = tsz_ff | word_type'(tal_ff); state_in = S_T1;
         end
         S_T1: begin
            tt_in = y; state_in = S_T2;
         end
         S_T2: begin
            mem_req.we = 1'b1; mem_req.wdata = tsz_ff | word_type'(tal_ff);
            state_in = t_ret_ff;
         end

         // push bp at the list head
         S_P0: begin
            mem_req.we = 1'b1; mem_req.wdata = word_type'(fh_ff); state_in = S_P1;
         end
         S_P1: begin
            mem_req.we = (fh_ff != '0); mem_req.wdata = word_type'(bp_ff[15:0]);
            state_in = S_P2;
         end
         S_P2: begin
            mem_req.we = 1'b1; fh_in = bp_ff[15:0]; state_in = co_ret_ff;
         end

         // unlink lx
         S_L0: state_in = S_L1;
         S_L1: begin
            lp_in = d16; state_in = S_L2;
         end
         S_L2: begin
            ln_in = d16;
            if (lp_ff != '0) begin
               mem_req.we = 1'b1; mem_req.wdata = word_type'(d16);
            end else begin
               fh_in = d16;
            end
            state_in = S_L3;
         end
         S_L3: begin
            mem_req.we = (ln_ff != '0); mem_req.wdata = word_type'(lp_ff);
            state_in = lr_ret_ff;
         end

         // allocate: block size, then first-fit walk
         S_A0: begin
            if (size_ff == '0) begin
               st_in = ST_NONE; res_in = '0; state_in = al_ret_ff;
            end else begin
               asize_in = (size_ff <= 16'd8) ? MIN_BLOCK : size_type'(align8(y));
               fp_in = fh_ff; steps_in = '0; state_in = S_F1;
            end
         end
         S_F1: state_in = (fp_ff == '0 || steps_ff == STEP_W'(HEAP_WORDS)) ? S_G0 : S_F2;
         S_F2: begin
            if (!neg) begin
               bp_in = addr_type'(fp_ff); state_in = S_PL0;
            end else begin
               state_in = S_F3;
            end
         end
         S_F3: begin
            steps_in = steps_ff + 1'b1; state_in = S_F4;
         end
         S_F4: begin
            fp_in = d16; state_in = S_F1;
         end

         // heap growth amount
         S_G0: begin
            g_in = align8(y); state_in = S_G1;
         end
         S_G1: begin
            if (neg) g_in = addr_type'(asize_ff);
            state_in = S_G2;
         end
         S_G2: begin
            tt_in = neg ? '0 : align8(y); state_in = S_G3;
         end
         S_G3: begin
            if (neg) g_in = tt_ff;
            state_in = S_G4;
         end
         S_G4: begin
            if (neg) begin
               st_in = ST_NOSPACE; res_in = '0; state_in = al_ret_ff;
            end else begin
               ext_ret_in = S_PL0; state_in = S_E0;
            end
         end

         // place: unlink, split when the rest is large enough
         S_PL0: begin
            abp_in = bp_ff; state_in = S_PL1;
         end
         S_PL1: begin
            pcs_in = dsz; lx_in = abp_ff; lr_ret_in = S_PL2; state_in = S_L0;
         end
         S_PL2: begin
            rem_in = size_type'(y); rem_ok_in = !neg; state_in = S_PL3;
         end
         S_PL3: begin
            tb_in = abp_ff; tal_in = 1'b1; state_in = S_T0;
            if (rem_ok_ff && rem_ff >= SPLIT_MIN) begin
               tsz_in = asize_ff; t_ret_in = S_PL4;
            end else begin
               tsz_in = pcs_ff; t_ret_in = S_AOK;
            end
         end
         S_PL4: begin
            tb_in = y; tsz_in = rem_ff; tal_in = 1'b0; t_ret_in = S_PL5; state_in = S_T0;
         end
         S_PL5: begin
            bp_in = tb_ff; co_ret_in = S_AOK; state_in = S_C0;
         end
         S_AOK: begin
            res_in = abp_ff[15:0]; st_in = ST_OK; state_in = al_ret_ff;
         end

         // dispatch by opcode
         S_OPS: begin
            case (op_ff)
               OP_ALLOC: begin
                  al_ret_in = S_DONE; state_in = S_A0;
               end
               OP_FREE: state_in = S_V0;
               OP_RESIZE: begin
                  al_ret_in = S_DONE;
                  state_in = (addr_ff == '0) ? S_A0 : S_V0;
               end
               default: state_in = S_DONE;
            endcase
         end

         // block check
         S_V0: begin
            if (addr_ff[2:0] != 3'b000 || addr_ff[15:4] == '0 || !neg) begin
               st_in = ST_NONE; state_in = S_DONE;
            end else begin
               state_in = S_V1;
            end
         end
         S_V1: state_in = S_V2;
         S_V2: begin
            if (!mem_rdata[0] || dsz[SIZE_W-1:4] == '0) begin
               st_in = ST_NONE; state_in = S_DONE;
            end else begin
               vcs_in = dsz; tt_in = y; nb_in = y; state_in = S_V3;
            end
         end
         S_V3: begin
            if (neg) begin
               st_in = ST_NONE; state_in = S_DONE;
            end else if (op_ff == OP_FREE) begin
               state_in = S_FR0;
            end else if (size_ff == '0) begin
               st_in = ST_NONE; state_in = S_FR0;
            end else begin
               state_in = S_RZ0;
            end
         end

         // free addr
         S_FR0: begin
            tb_in = addr_type'(addr_ff); tsz_in = vcs_ff; tal_in = 1'b0;
            t_ret_in = S_FR1; state_in = S_T0;
         end
         S_FR1: begin
            bp_in = addr_type'(addr_ff); co_ret_in = S_DONE; state_in = S_C0;
         end

         // resize: in place, absorb next, or move
         S_RZ0: state_in = S_RZ1;
         S_RZ1: begin
            ns_in = dsz; na_in = mem_rdata[0]; tt_in = y; state_in = S_RZ2;
         end
         S_RZ2: begin
            if (!neg) begin
               res_in = addr_ff; state_in = S_DONE;
            end else begin
               state_in = S_RZ3;
            end
         end
         S_RZ3: begin
            tsz_in = size_type'(y); state_in = S_RZ4;
         end
         S_RZ4: begin
            tt_in = y; state_in = S_RZ5;
         end
         S_RZ5: begin
            if (neg && !na_ff) begin
               lx_in = nb_ff; lr_ret_in = S_AB1; state_in = S_L0;
            end else begin
               al_ret_in = S_MV1; state_in = S_A0;
            end
         end
         S_AB1: begin
            tb_in = addr_type'(addr_ff); tal_in = 1'b1; t_ret_in = S_DONE;
            res_in = addr_ff; state_in = S_T0;
         end
         S_MV1: begin
            tt_in = y;
            state_in = (st_ff != ST_OK) ? S_DONE : S_MV2;
         end
         S_MV2: begin
            cbytes_in = neg ? size_ff : tt_ff[15:0]; csrc_in = addr_ff; state_in = S_FR0;
         end

         // hand over to the result register
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = load | (rsp_valid_ff & ~rsp_ready);
      rsp_data_in  = load ? '{result_addr: res_ff, status: st_ff, copy_src: csrc_ff,
                              copy_bytes: cbytes_ff} : rsp_data_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;  ready_ff <= 1'b0;  fh_ff <= '0;  top_ff <= '0;
         chunk_ff <= CHUNK_RESET;  rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;  ready_ff <= ready_in;  fh_ff <= fh_in;  top_ff <= top_in;
         chunk_ff <= chunk_in;  rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      lr_ret_ff <= lr_ret_in; co_ret_ff <= co_ret_in; t_ret_ff <= t_ret_in;
      al_ret_ff <= al_ret_in; ext_ret_ff <= ext_ret_in;
      op_ff <= op_in; size_ff <= size_in; addr_ff <= addr_in;
      res_ff <= res_in; st_ff <= st_in; csrc_ff <= csrc_in; cbytes_ff <= cbytes_in;
      bp_ff <= bp_in; nb_ff <= nb_in; tb_ff <= tb_in; tt_ff <= tt_in;
      g_ff <= g_in; abp_ff <= abp_in; lx_ff <= lx_in;
      s_ff <= s_in; ps_ff <= ps_in; ns_ff <= ns_in; tsz_ff <= tsz_in;
      asize_ff <= asize_in; pcs_ff <= pcs_in; vcs_ff <= vcs_in; rem_ff <= rem_in;
      pa_ff <= pa_in; na_ff <= na_in; tal_ff <= tal_in; rem_ok_ff <= rem_ok_in;
      lp_ff <= lp_in; ln_ff <= ln_in; fp_ff <= fp_in; steps_ff <= steps_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // once built, the heap stays built
   assert property (@(posedge clock) disable iff (reset) ready_ff |=> ready_ff)
      else $error("heap lost its initialized flag");

   // the heap never grows past capacity and stays 8-aligned
   assert property (@(posedge clock) disable iff (reset)
      (32'(top_ff) <= CAP_BYTES) && (top_ff[2:0] == 3'b000))
      else $error("heap top out of range");

   // a copy is only reported for a successful move
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.copy_bytes != '0) |->
      (rsp_data_ff.status == ST_OK && rsp_data_ff.result_addr != '0))
      else $error("copy reported without a new block");

   // a finished request only leaves once the result slot is free
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && !rsp_ready) |=> state_ff == S_DONE)
      else $error("result dropped while output stalled");

endmodule

### hw/rtl/explicit_free_list_allocator.sv
// One request at a time, one memory access per cycle through a shared adder; the
// result register lets the next request in while it waits. A request before init
// runs the init first.
// Reset (synchronous): empty, uninitialized heap, chunk 4096; memory not cleared.
`timescale 1ns / 1ps
module explicit_free_list_allocator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  efla_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output efla_pkg::rsp_type    rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  efla_pkg::size_type   csr_data
);
   import efla_pkg::*;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;
   mem_req_type mem_req;
   word_type    mem_rdata;

   // chunk register always accepts writes
   assign csr_ready = 1'b1;

   efla_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   efla_mem u_mem (
      .clock     (clock),
      .reset     (reset),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   efla_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .alu_req   (alu_req),
      .alu_rsp   (alu_rsp),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

endmodule

### sim/tb.sv
// Self-checking testbench for the explicit free list allocator.
// Depends on efla_pkg and explicit_free_list_allocator from hw/rtl.
`timescale 1ns / 1ps
module tb;
   import efla_pkg::*;

   localparam int unsigned HW        = HEAP_WORDS;
   localparam int unsigned CAP       = CAP_BYTES;
   localparam int unsigned LIMIT     = 3000000;
   localparam int unsigned HOLD_LO   = 6000;
   localparam int unsigned HOLD_HI   = 6800;
   localparam int unsigned QUIET_LO  = 20000;
   localparam int unsigned QUIET_HI  = 26000;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   req_type  req_data = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   rsp_type  rsp_data;
   logic     csr_valid = 1'b0;
   logic     csr_ready;
   size_type csr_data = '0;

   explicit_free_list_allocator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_type     pending_reqs[$];
   rsp_type     expected_rsps[$];
   logic [15:0] live_blocks[$];
   int          errors = 0;
   int unsigned cycle = 0;

   // ---------------- heap predictor ----------------
   int unsigned heap_mem[HW];
   bit          heap_seen[HW];
   int unsigned snap_mem[HW];
   bit          snap_seen[HW];
   int unsigned list_head = 0, top = 0, snap_head, snap_top;
   bit          ready_flag = 0, snap_ready;
   bit          unwritten_read;
   int unsigned chunk_cfg = 4096;

   function automatic int unsigned hrd(int unsigned a);
      int unsigned i;
      i = a >> 2;
      if ((a & 3) != 0 || i >= HW) return 0;
      if (!heap_seen[i]) unwritten_read = 1;
      return heap_mem[i];
   endfunction

   function automatic void hwr(int unsigned a, int unsigned v);
      int unsigned i;
      i = a >> 2;
      if ((a & 3) != 0 || i >= HW) return;
      heap_mem[i] = v;
      heap_seen[i] = 1;
   endfunction

   function automatic int unsigned blk_size(int unsigned bp);
      return hrd(bp - 4) & ~32'd7;
   endfunction

   function automatic int unsigned blk_used(int unsigned bp);
      return hrd(bp - 4) & 1;
   endfunction

   function automatic void set_tags(int unsigned bp, int unsigned sz, int unsigned al);
      hwr(bp - 4, sz | al);
      hwr(bp + sz - 8, sz | al);
   endfunction

   function automatic void unlink(int unsigned bp);
      int unsigned p, n;
      p = hrd(bp) & 16'hFFFF;
      n = hrd(bp + 4) & 16'hFFFF;
      if (p != 0) hwr(p + 4, n); else list_head = n;
      if (n != 0) hwr(n, p);
   endfunction

   function automatic void push_free(int unsigned bp);
      bp &= 16'hFFFF;
      hwr(bp + 4, list_head);
      if (list_head != 0) hwr(list_head, bp);
      hwr(bp, 0);
      list_head = bp;
   endfunction

   function automatic int unsigned merge(int unsigned bp);
      int unsigned s, nb, pa, na, ps, ns, pb;
      s = blk_size(bp);
      nb = bp + s;
      pa = hrd(bp - 8) & 1;
      na = blk_used(nb);
      if (pa == 0 && na == 0) begin
         ps = hrd(bp - 8) & ~32'd7;
         pb = bp - ps;
         ns = blk_size(nb);
         unlink(pb);
         unlink(nb);
         s += ps + ns;
         bp = pb;
         set_tags(bp, s, 0);
      end else if (na == 0) begin
         ns = blk_size(nb);
         unlink(nb);
         s += ns;
         set_tags(bp, s, 0);
      end else if (pa == 0) begin
         ps = hrd(bp - 8) & ~32'd7;
         pb = bp - ps;
         unlink(pb);
         s += ps;
         bp = pb;
         set_tags(bp, s, 0);
      end
      push_free(bp);
      return bp;
   endfunction

   function automatic int unsigned grow(int unsigned g);
      int unsigned bp;
      bp = top;
      set_tags(bp, g, 0);
      hwr(bp + g - 4, 1);
      top = (bp + g) & 32'h1FFFF;
      return merge(bp);
   endfunction

   function automatic void rebuild();
      int unsigned g, avail;
      g = (chunk_cfg + 7) & ~32'd7;
      avail = (CAP - 16) & ~32'd7;
      hwr(0, 0);
      hwr(4, 9);
      hwr(8, 9);
      hwr(12, 1);
      list_head = 0;
      top = 16;
      ready_flag = 1;
      if (g < 16) g = 16;
      if (g > avail) g = avail;
      void'(grow(g));
   endfunction

   function automatic void carve(int unsigned bp, int unsigned asize);
      int unsigned cs;
      cs = blk_size(bp);
      unlink(bp);
      if (cs >= asize && cs - asize >= 24) begin
         set_tags(bp, asize, 1);
         set_tags(bp + asize, cs - asize, 0);
         void'(merge(bp + asize));
      end else begin
         set_tags(bp, cs, 1);
      end
   endfunction

   function automatic int unsigned first_fit(int unsigned asize);
      int unsigned p, steps;
      p = list_head;
      for (steps = 0; p != 0 && steps < HW; steps++) begin
         if (blk_size(p) >= asize) return p;
         p = hrd(p + 4) & 16'hFFFF;
      end
      return 0;
   endfunction

   function automatic int unsigned take(int unsigned size, output logic [1:0] st);
      int unsigned asize, bp, want, avail;
      st = ST_OK;
      if (size == 0) begin
         st = ST_NONE;
         return 0;
      end
      asize = (size <= 8) ? 16 : 8 * ((size + 15) / 8);
      bp = first_fit(asize);
      if (bp == 0) begin
         want = (chunk_cfg + 7) & ~32'd7;
         avail = (top < CAP) ? ((CAP - top) & ~32'd7) : 0;
         if (want < asize) want = asize;
         if (want > avail) want = avail;
         if (want < asize) begin
            st = ST_NOSPACE;
            return 0;
         end
         bp = grow(want);
      end
      carve(bp, asize);
      return bp & 16'hFFFF;
   endfunction

   function automatic bit is_block(int unsigned a);
      int unsigned s;
      if ((a & 7) != 0 || a < 16 || a >= top) return 0;
      if (blk_used(a) == 0) return 0;
      s = blk_size(a);
      return s >= 16 && a + s <= top;
   endfunction

   function automatic void release_blk(int unsigned a);
      set_tags(a, blk_size(a), 0);
      void'(merge(a));
   endfunction

   // expected response for one request; updates the heap image
   function automatic rsp_type heap_step(req_type r);
      rsp_type     o;
      logic [1:0]  st;
      int unsigned sz, ad, cs, nb, ns, np, pay;
      o = '0;
      st = ST_OK;
      sz = r.req_size;
      ad = r.block_addr;
      if (r.opcode != OP_INIT && !ready_flag) rebuild();
      case (r.opcode)
         OP_INIT: rebuild();
         OP_ALLOC: o.result_addr = 16'(take(sz, st));
         OP_FREE: begin
            if (ad != 0 && is_block(ad)) release_blk(ad); else st = ST_NONE;
         end
         default: begin
            if (ad == 0) begin
               o.result_addr = 16'(take(sz, st));
            end else if (!is_block(ad)) begin
               st = ST_NONE;
            end else if (sz == 0) begin
               release_blk(ad);
               st = ST_NONE;
            end else begin
               cs = blk_size(ad);
               nb = ad + cs;
               ns = blk_size(nb);
               if (sz + 16 <= cs) begin
                  o.result_addr = 16'(ad);
               end else if (blk_used(nb) == 0 && ns + cs > sz + 8) begin
                  unlink(nb);
                  set_tags(ad, ns + cs, 1);
                  o.result_addr = 16'(ad);
               end else begin
                  np = take(sz, st);
                  if (np != 0) begin
                     pay = cs - 8;
                     o.copy_src = 16'(ad);
                     o.copy_bytes = 16'((sz < pay) ? sz : pay);
                     release_blk(ad);
                     o.result_addr = 16'(np);
                  end
               end
            end
         end
      endcase
      o.status = st;
      return o;
   endfunction

   function automatic void drop_live(logic [15:0] a);
      foreach (live_blocks[i]) begin
         if (live_blocks[i] == a) begin
            live_blocks.delete(i);
            return;
         end
      end
   endfunction

   // predict, queue the request, and track live blocks; a request with a
   // random address that would touch never-written memory becomes a null free
   task automatic issue(input req_type r, input bit noisy, output rsp_type o);
      if (noisy) begin
         snap_mem = heap_mem;
         snap_seen = heap_seen;
         snap_head = list_head;
         snap_top = top;
         snap_ready = ready_flag;
      end
      unwritten_read = 0;
      o = heap_step(r);
      if (noisy && unwritten_read) begin
         heap_mem = snap_mem;
         heap_seen = snap_seen;
         list_head = snap_head;
         top = snap_top;
         ready_flag = snap_ready;
         r.opcode = OP_FREE;
         r.block_addr = '0;
         o = heap_step(r);
      end
      if (r.opcode == OP_INIT) begin
         live_blocks.delete();
      end else if (o.copy_bytes != 0) begin
         drop_live(r.block_addr);
         live_blocks.push_back(o.result_addr);
      end else if (o.status == ST_OK && o.result_addr != 0 && o.result_addr != r.block_addr) begin
         live_blocks.push_back(o.result_addr);
      end else if (r.opcode == OP_FREE && o.status == ST_OK) begin
         drop_live(r.block_addr);
      end else if (r.opcode == OP_RESIZE && r.req_size == 0) begin
         drop_live(r.block_addr);
      end
      pending_reqs.push_back(r);
      expected_rsps.push_back(o);
   endtask

   // ---------------- mismatch reporting ----------------
   task automatic report(input string msg);
      $display("tb: mismatch at cycle %0d: %s", cycle, msg);
      errors++;
   endtask

   function automatic bit idle_roll();
      if (cycle >= QUIET_LO && cycle < QUIET_HI) return 0;
      return $urandom_range(99) < 29;
   endfunction

   // cycle counter and run limit
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_reqs.size() > 0 && !idle_roll()) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off counted here
   int unsigned rx_cycles = 0;
   always @(posedge clock) begin
      rx_cycles <= rx_cycles + 1;
      if (reset) rsp_ready <= 1'b0;
      else if (rx_cycles >= HOLD_LO && rx_cycles < HOLD_HI) rsp_ready <= 1'b0;
      else rsp_ready <= !idle_roll();
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            report("response with nothing expected");
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data.result_addr != e.result_addr)
               report($sformatf("result_addr %h want %h", rsp_data.result_addr, e.result_addr));
            if (rsp_data.status != e.status)
               report($sformatf("status %0d want %0d", rsp_data.status, e.status));
            if (rsp_data.copy_src != e.copy_src)
               report($sformatf("copy_src %h want %h", rsp_data.copy_src, e.copy_src));
            if (rsp_data.copy_bytes != e.copy_bytes)
               report($sformatf("copy_bytes %h want %h", rsp_data.copy_bytes, e.copy_bytes));
         end
      end
   end

   // ---------------- stimulus ----------------
   task automatic wait_drained();
      while (expected_rsps.size() != 0 || pending_reqs.size() != 0 || req_valid)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_chunk(input int unsigned v);
      wait_drained();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= size_type'(v);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      chunk_cfg = v & 32'h1FFFF;
   endtask

   function automatic logic [15:0] pick_size();
      int unsigned k;
      k = $urandom_range(99);
      if (k < 70) return 16'($urandom_range(1, 128));
      if (k < 90) return 16'($urandom_range(129, 1024));
      if (k < 97) return 16'($urandom_range(1025, 8192));
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic req_type mk(logic [1:0] op, int unsigned sz, int unsigned ad);
      req_type r;
      r.opcode = op;
      r.req_size = 16'(sz);
      r.block_addr = 16'(ad);
      return r;
   endfunction

   initial begin
      rsp_type     o;
      req_type     r;
      logic [15:0] a, b, c, e, f, g, h;
      int unsigned k, n, chunks[5];
      bit          noisy;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: request before init, then edge cases
      issue(mk(OP_ALLOC, 24, 0), 0, o);
      issue(mk(OP_INIT, 16'hFFFF, 16'hFFFF), 0, o);
      issue(mk(OP_ALLOC, 0, 0), 0, o);
      issue(mk(OP_ALLOC, 1, 0), 0, o);     a = o.result_addr;
      issue(mk(OP_ALLOC, 8, 0), 0, o);     b = o.result_addr;
      issue(mk(OP_ALLOC, 9, 0), 0, o);     c = o.result_addr;
      issue(mk(OP_ALLOC, 65535, 0), 0, o);
      issue(mk(OP_FREE, 0, 0), 0, o);
      issue(mk(OP_FREE, 0, 3), 1, o);
      issue(mk(OP_FREE, 0, 16'hFFF8), 1, o);
      issue(mk(OP_RESIZE, 40, 0), 0, o);
      issue(mk(OP_RESIZE, 1, c), 0, o);    // fits in place
      issue(mk(OP_RESIZE, 100, b), 0, o);  // neighbor in use: moves
      issue(mk(OP_ALLOC, 32, 0), 0, o);    e = o.result_addr;
      issue(mk(OP_ALLOC, 32, 0), 0, o);    f = o.result_addr;
      issue(mk(OP_ALLOC, 32, 0), 0, o);    g = o.result_addr;
      issue(mk(OP_FREE, 0, f), 0, o);
      issue(mk(OP_RESIZE, 60, e), 0, o);   // absorbs the freed neighbor
      issue(mk(OP_RESIZE, 0, g), 0, o);    // shrink to nothing frees
      issue(mk(OP_FREE, 0, a), 0, o);
      issue(mk(OP_FREE, 0, a), 0, o);      // double free
      issue(mk(OP_RESIZE, 10, a), 0, o);   // stale block
      issue(mk(OP_RESIZE, 10, 16'hFFF0), 1, o);
      issue(mk(OP_ALLOC, 40000, 0), 0, o); h = o.result_addr;
      issue(mk(OP_RESIZE, 40000, c), 0, o); // no room to move
      issue(mk(OP_FREE, 0, h), 0, o);

      // random phases over several chunk settings
      chunks = '{8, 65536, $urandom_range(8, 65536), 24, 4096};
      for (int p = 0; p < 5; p++) begin
         write_chunk(chunks[p]);
         issue(mk(OP_INIT, $urandom_range(0, 65535), $urandom_range(0, 65535)), 0, o);
         for (n = 0; n < 345; n++) begin
            k = $urandom_range(99);
            if (live_blocks.size() > 300 && k >= 2 && k < 42) k = 50;
            noisy = 0;
            if (k < 2) begin
               r = mk(OP_INIT, $urandom_range(0, 65535), $urandom_range(0, 65535));
            end else if (k < 42 || live_blocks.size() == 0 && k < 85) begin
               r = mk(OP_ALLOC, pick_size(), $urandom_range(0, 65535));
            end else if (k < 65) begin
               a = live_blocks[$urandom_range(live_blocks.size() - 1)];
               r = mk(OP_FREE, $urandom_range(0, 65535), a);
            end else if (k < 85) begin
               a = live_blocks[$urandom_range(live_blocks.size() - 1)];
               r = mk(OP_RESIZE, ($urandom_range(19) == 0) ? 0 : pick_size(), a);
            end else if (k < 90) begin
               r = mk(OP_RESIZE, pick_size(), 0);
            end else begin
               r = mk(2'($urandom_range(1, 3)), $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
               noisy = 1;
            end
            issue(r, noisy, o);
            // keep the generator at most a few requests ahead of the driver
            while (pending_reqs.size() > 4) @(posedge clock);
         end
      end

      wait_drained();
      repeat (200) @(posedge clock);
      if (errors == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

endmodule
